FILE: hw/rtl/blse_pkg.sv
// Shared types, codes and field widths of the bounded list sequence engine.
package blse_pkg;

  localparam int OP_W  = 4;
  localparam int VAL_W = 32;
  localparam int POS_W = 9;
  localparam int ST_W  = 3;
  localparam int CNT_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_DEL_FIRST = 4'd6,
    OP_DEL_ALL   = 4'd7,
    OP_CLEAR     = 4'd8,
    OP_READ_AT   = 4'd9
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_WAIT,
    S_PLACE,
    S_WSTART,
    S_WALK,
    S_LINK,
    S_SCAN,
    S_FIX,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    latch_in;
    logic    alloc_rd;
    logic    alloc_take;
    logic    alloc_new;
    logic    ins_front;
    logic    walk_start;
    logic    advance;
    logic    ins_write;
    logic    ins_link;
    logic    del_node;
    logic    fix;
    logic    rd_capture;
    logic    clear;
    logic    set_status;
    status_e status;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic pos_zero;
    logic pos_gt_count;
    logic pos_ge_count;
    logic pop_free;
    logic rem_zero;
    logic match;
    logic has_prev;
    logic pend;
    logic none_removed;
    logic front_ins;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: hw/rtl/bounded_list_sequence_engine.sv
// Top level of the bounded list sequence engine: controller plus datapath.
// Holds an ordered list of up to CAPACITY signed 32-bit values as linked nodes in two
// single-port-read RAMs (values and links), one transaction at a time. How long a request
// takes is set by the list walk, one link RAM read per node visited; front inserts, clear and
// rejected requests need no walk. An insert that reuses a node from the free chain first reads
// that node's link to move the chain on. Nodes never used are handed out by a fill count, so
// no clearing pass follows reset. A finished result sits in an output register; the next
// request is taken while it waits, and a second result stalls only until the first is taken.
module bounded_list_sequence_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [blse_pkg::OP_W-1:0]           operation_i,
  input  logic signed [blse_pkg::VAL_W-1:0]   value_i,
  input  logic [blse_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [blse_pkg::ST_W-1:0]           status_o,
  output logic signed [blse_pkg::VAL_W-1:0]   read_data_o,
  output logic [blse_pkg::CNT_W-1:0]          element_count_o,
  output logic [blse_pkg::CNT_W-1:0]          removed_count_o
);
  import blse_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  blse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  blse_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_data_o     (read_data_o),
    .element_count_o (element_count_o),
    .removed_count_o (removed_count_o)
  );

endmodule

FILE: hw/rtl/blse_ram.sv
// Generic single write port, single read port RAM with registered read data.
module blse_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/blse_ctrl.sv
// Controller state machine: sequences allocation, list walks, scans and result hand-off.
module blse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blse_pkg::dp_stat_t  stat_i,
  output blse_pkg::ctrl_cmd_t cmd_o
);
  import blse_pkg::*;

  state_e state_q, state_d;
  logic   is_scan;
  logic   is_ins;

  assign is_scan = (stat_i.op == OP_DEL_FIRST) || (stat_i.op == OP_DEL_ALL);
  assign is_ins  = (stat_i.op == OP_INS_FRONT) || (stat_i.op == OP_INS_BACK) ||
                   (stat_i.op == OP_INS_AT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_INS_FRONT, OP_INS_BACK: begin
            state_d = stat_i.full ? S_DONE : S_ALLOC;
          end
          OP_INS_AT: begin
            if (stat_i.full) state_d = S_DONE;
            else if (!stat_i.empty && !stat_i.pos_zero && stat_i.pos_gt_count) state_d = S_DONE;
            else state_d = S_ALLOC;
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            state_d = stat_i.empty ? S_DONE : S_WSTART;
          end
          OP_DEL_AT, OP_READ_AT: begin
            state_d = stat_i.pos_ge_count ? S_DONE : S_WSTART;
          end
          OP_DEL_FIRST, OP_DEL_ALL: state_d = S_WSTART;
          OP_CLEAR: state_d = S_CLEAR;
          default: state_d = S_DONE;
        endcase
      end
      S_ALLOC: begin
        state_d = stat_i.pop_free ? S_ALLOC_WAIT : S_PLACE;
      end
      S_ALLOC_WAIT: state_d = S_PLACE;
      S_PLACE: begin
        state_d = stat_i.front_ins ? S_DONE : S_WSTART;
      end
      S_WSTART: begin
        state_d = is_scan ? S_SCAN : S_WALK;
      end
      S_WALK: begin
        if (stat_i.rem_zero) begin
          if (is_ins) state_d = S_LINK;
          else if (stat_i.op == OP_READ_AT) state_d = S_DONE;
          else state_d = stat_i.has_prev ? S_FIX : S_DONE;
        end
      end
      S_LINK: state_d = S_DONE;
      S_SCAN: begin
        if (stat_i.rem_zero) begin
          state_d = stat_i.pend ? S_FIX : S_DONE;
        end else if (stat_i.match && (stat_i.op == OP_DEL_FIRST)) begin
          state_d = stat_i.has_prev ? S_FIX : S_DONE;
        end
      end
      S_FIX:   state_d = S_DONE;
      S_CLEAR: state_d = S_DONE;
      S_DONE: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ST_OK;
    in_ready_o   = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.latch_in = in_valid_i;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_INS_FRONT, OP_INS_BACK: begin
            cmd_o.set_status = stat_i.full;
            cmd_o.status     = ST_FULL;
          end
          OP_INS_AT: begin
            if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else if (!stat_i.empty && !stat_i.pos_zero && stat_i.pos_gt_count) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK: begin
            cmd_o.set_status = stat_i.empty;
            cmd_o.status     = ST_EMPTY;
          end
          OP_DEL_AT, OP_READ_AT: begin
            cmd_o.set_status = stat_i.pos_ge_count;
            cmd_o.status     = ST_RANGE;
          end
          default: ;
        endcase
      end
      S_ALLOC: begin
        cmd_o.alloc_rd  = stat_i.pop_free;
        cmd_o.alloc_new = !stat_i.pop_free;
      end
      S_ALLOC_WAIT: cmd_o.alloc_take = 1'b1;
      S_PLACE: cmd_o.ins_front = stat_i.front_ins;
      S_WSTART: cmd_o.walk_start = 1'b1;
      S_WALK: begin
        if (!stat_i.rem_zero) begin
          cmd_o.advance = 1'b1;
        end else if (is_ins) begin
          cmd_o.ins_write = 1'b1;
        end else if (stat_i.op == OP_READ_AT) begin
          cmd_o.rd_capture = 1'b1;
        end else begin
          cmd_o.del_node = 1'b1;
        end
      end
      S_LINK: cmd_o.ins_link = 1'b1;
      S_SCAN: begin
        if (stat_i.rem_zero) begin
          cmd_o.set_status = stat_i.none_removed;
          cmd_o.status     = ST_NOTFOUND;
        end else if (stat_i.match) begin
          cmd_o.del_node = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_FIX:   cmd_o.fix = 1'b1;
      S_CLEAR: cmd_o.clear = 1'b1;
      S_DONE:  cmd_o.load_out = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/blse_dp.sv
// Datapath: node value and link RAMs, list pointers, fill count, walk registers, result register.
module blse_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blse_pkg::ctrl_cmd_t                 cmd_i,
  output blse_pkg::dp_stat_t                  stat_o,
  input  logic [blse_pkg::OP_W-1:0]           operation_i,
  input  logic signed [blse_pkg::VAL_W-1:0]   value_i,
  input  logic [blse_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [blse_pkg::ST_W-1:0]           status_o,
  output logic signed [blse_pkg::VAL_W-1:0]   read_data_o,
  output logic [blse_pkg::CNT_W-1:0]          element_count_o,
  output logic [blse_pkg::CNT_W-1:0]          removed_count_o
);
  import blse_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // list control state
  logic [IW-1:0] first_q, first_d, last_q, last_d, free_q, free_d;
  logic [CW-1:0] count_q, count_d, hw_q, hw_d;
  logic          out_valid_q, out_valid_d;

  // per-transaction working registers
  op_e                 op_q, op_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IW-1:0]       cur_q, cur_d, prev_q, prev_d, new_q, new_d;
  logic [CW-1:0]       rem_q, rem_d, removed_q, removed_d;
  logic                has_prev_q, has_prev_d, pend_q, pend_d;
  status_e             status_q, status_d;
  logic [VAL_W-1:0]    rd_q, rd_d;
  status_e             out_status_q, out_status_d;
  logic [VAL_W-1:0]    out_rd_q, out_rd_d;
  logic [CNT_W-1:0]    out_count_q, out_count_d, out_removed_q, out_removed_d;

  // RAM ports
  logic             link_we, val_we;
  logic [IW-1:0]    link_wa, raddr;
  logic [IW-1:0]    link_wd, lk;
  logic [VAL_W-1:0] vd;

  blse_ram #(.Width(IW), .Depth(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_wa),
    .wdata_i (link_wd),
    .raddr_i (raddr),
    .rdata_o (lk)
  );

  blse_ram #(.Width(VAL_W), .Depth(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (new_q),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (vd)
  );

  always_comb begin
    stat_o.op           = op_q;
    stat_o.empty        = (count_q == '0);
    stat_o.full         = (count_q == CW'(CAPACITY));
    stat_o.pos_zero     = (pos_q == '0);
    stat_o.pos_gt_count = (XW'(pos_q) > XW'(count_q));
    stat_o.pos_ge_count = (XW'(pos_q) >= XW'(count_q));
    stat_o.pop_free     = (count_q < hw_q);
    stat_o.rem_zero     = (rem_q == '0);
    stat_o.match        = (vd == val_q);
    stat_o.has_prev     = has_prev_q;
    stat_o.pend         = pend_q;
    stat_o.none_removed = (removed_q == '0);
    stat_o.front_ins    = (op_q == OP_INS_FRONT) ||
                          ((op_q == OP_INS_BACK) && (count_q == '0)) ||
                          ((op_q == OP_INS_AT) && ((count_q == '0) || (pos_q == '0)));
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  always_comb begin
    first_d       = first_q;
    last_d        = last_q;
    free_d        = free_q;
    count_d       = count_q;
    hw_d          = hw_q;
    op_d          = op_q;
    val_d         = val_q;
    pos_d         = pos_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    new_d         = new_q;
    rem_d         = rem_q;
    removed_d     = removed_q;
    has_prev_d    = has_prev_q;
    pend_d        = pend_q;
    status_d      = status_q;
    rd_d          = rd_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_rd_d      = out_rd_q;
    out_count_d   = out_count_q;
    out_removed_d = out_removed_q;
    link_we       = 1'b0;
    link_wa       = cur_q;
    link_wd       = free_q;
    val_we        = 1'b0;
    raddr         = cur_q;

    if (cmd_i.latch_in) begin
      op_d      = op_e'(operation_i);
      val_d     = value_i;
      pos_d     = position_i;
      status_d  = ST_OK;
      rd_d      = '0;
      removed_d = '0;
    end
    if (cmd_i.set_status) status_d = cmd_i.status;

    if (cmd_i.alloc_rd) raddr = free_q;
    if (cmd_i.alloc_take) begin
      new_d  = free_q;
      free_d = lk;
    end
    if (cmd_i.alloc_new) begin
      new_d = IW'(hw_q);
      hw_d  = hw_q + CW'(1);
    end

    if (cmd_i.ins_front) begin
      val_we  = 1'b1;
      link_we = 1'b1;
      link_wa = new_q;
      link_wd = first_q;
      first_d = new_q;
      if (count_q == '0) last_d = new_q;
      count_d = count_q + CW'(1);
    end

    if (cmd_i.walk_start) begin
      cur_d      = (op_q == OP_INS_BACK) ? last_q : first_q;
      has_prev_d = 1'b0;
      pend_d     = 1'b0;
      case (op_q)
        OP_INS_AT:                 rem_d = CW'(pos_q - POS_W'(1));
        OP_DEL_BACK:               rem_d = count_q - CW'(1);
        OP_DEL_AT, OP_READ_AT:     rem_d = CW'(pos_q);
        OP_DEL_FIRST, OP_DEL_ALL:  rem_d = count_q;
        default:                   rem_d = '0;
      endcase
      raddr = cur_d;
    end

    if (cmd_i.advance) begin
      if (pend_q) begin
        link_we = 1'b1;
        link_wa = prev_q;
        link_wd = cur_q;
        pend_d  = 1'b0;
      end
      prev_d     = cur_q;
      has_prev_d = 1'b1;
      cur_d      = lk;
      raddr      = lk;
      rem_d      = rem_q - CW'(1);
    end

    if (cmd_i.ins_write) begin
      val_we  = 1'b1;
      link_we = 1'b1;
      link_wa = new_q;
      link_wd = lk;
    end

    if (cmd_i.ins_link) begin
      link_we = 1'b1;
      link_wa = cur_q;
      link_wd = new_q;
      if (cur_q == last_q) last_d = new_q;
      count_d = count_q + CW'(1);
    end

    if (cmd_i.del_node) begin
      link_we   = 1'b1;
      link_wa   = cur_q;
      link_wd   = free_q;
      free_d    = cur_q;
      count_d   = count_q - CW'(1);
      removed_d = removed_q + CW'(1);
      cur_d     = lk;
      raddr     = lk;
      rem_d     = rem_q - CW'(1);
      if (has_prev_q) pend_d = 1'b1;
      else first_d = lk;
      if (cur_q == last_q) last_d = prev_q;
      if (count_q == CW'(1)) begin
        first_d = '0;
        last_d  = '0;
      end
    end

    if (cmd_i.fix) begin
      link_we = 1'b1;
      link_wa = prev_q;
      link_wd = cur_q;
      pend_d  = 1'b0;
    end

    if (cmd_i.rd_capture) rd_d = vd;

    // whole list goes onto the free chain in one splice
    if (cmd_i.clear && (count_q != '0)) begin
      link_we   = 1'b1;
      link_wa   = last_q;
      link_wd   = free_q;
      free_d    = first_q;
      removed_d = count_q;
      count_d   = '0;
      first_d   = '0;
      last_d    = '0;
    end

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.load_out) begin
      out_valid_d   = 1'b1;
      out_status_d  = status_q;
      out_rd_d      = rd_q;
      out_count_d   = CNT_W'(count_q);
      out_removed_d = CNT_W'(removed_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      last_q      <= '0;
      free_q      <= '0;
      count_q     <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      last_q      <= last_d;
      free_q      <= free_d;
      count_q     <= count_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    val_q         <= val_d;
    pos_q         <= pos_d;
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    new_q         <= new_d;
    rem_q         <= rem_d;
    removed_q     <= removed_d;
    has_prev_q    <= has_prev_d;
    pend_q        <= pend_d;
    status_q      <= status_d;
    rd_q          <= rd_d;
    out_status_q  <= out_status_d;
    out_rd_q      <= out_rd_d;
    out_count_q   <= out_count_d;
    out_removed_q <= out_removed_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign read_data_o     = out_rd_q;
  assign element_count_o = out_count_q;
  assign removed_count_o = out_removed_q;

  // list never holds more nodes than have ever been handed out
  a_count_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hw_q) else $error("element count above fill count");

  a_fill_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= CW'(CAPACITY)) else $error("fill count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while held");

  a_alloc_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.alloc_rd || cmd_i.alloc_new) |-> (count_q < CW'(CAPACITY)))
    else $error("node allocated from a full store");

endmodule
